// ===== hw/rtl/dsa_pkg.sv =====
// Shared types, select codes and constants for the DSA sign and verify block.
`timescale 1ns / 1ps

package dsa_pkg;

   localparam int DSA_MOD_BITS = 32;
   localparam int CSR_WIDTH    = 32;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MODULUS_P      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORDER_Q        = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GENERATOR_SEED = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PRIVATE_KEY    = 2'd3;

   localparam logic [CSR_WIDTH-1:0] RST_MODULUS_P      = 32'd23;
   localparam logic [CSR_WIDTH-1:0] RST_ORDER_Q        = 32'd11;
   localparam logic [CSR_WIDTH-1:0] RST_GENERATOR_SEED = 32'd2;
   localparam logic [CSR_WIDTH-1:0] RST_PRIVATE_KEY    = 32'd3;

   localparam logic FUNC_SIGN   = 1'b0;
   localparam logic FUNC_VERIFY = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] hash_value;
      logic [31:0] nonce;
      logic [31:0] sig_r;
      logic [31:0] sig_s;
   } dsa_req_type;

   typedef struct packed {
      logic [31:0] out_r;
      logic [31:0] out_s;
      logic        verified;
      logic        bad_operand;
   } dsa_rsp_type;

   typedef enum logic [2:0] {
      OP_MOV,
      OP_SHR,
      OP_ADDM,
      OP_SUBM,
      OP_DIV,
      OP_MULM
   } dsa_op_type;

   typedef enum logic [4:0] {
      SEL_ZERO, SEL_ONE, SEL_P, SEL_PM1, SEL_Q, SEL_H, SEL_X,
      SEL_HS, SEL_K, SEL_R, SEL_S,
      SEL_XR, SEL_HR, SEL_EXP, SEL_BASE, SEL_ACC, SEL_G, SEL_Y, SEL_W,
      SEL_U1, SEL_U2, SEL_T0, SEL_T1, SEL_T2, SEL_T3, SEL_R0, SEL_R1,
      SEL_QUO, SEL_VR, SEL_VS
   } dsa_sel_type;

   typedef struct packed {
      logic        go;
      dsa_op_type  op;
      dsa_sel_type src_a;
      dsa_sel_type src_b;
      dsa_sel_type src_m;
      dsa_sel_type dest;
      logic        latch_item;
      logic        load_rsp;
      logic        verified;
      logic        bad_operand;
   } dsa_cmd_type;

   typedef struct packed {
      logic done;
      logic p_lt2;
      logic q_lt2;
      logic pq_zero;
      logic exp_zero;
      logic exp_lsb;
      logic r1_zero;
      logic r0_one;
      logic sig_in_range;
      logic v_eq_r;
   } dsa_status_type;

endpackage

// ===== hw/rtl/dsa_sign_and_verify.sv =====
// DSA sign and verify: top level joining the controller and the datapath.
`timescale 1ns / 1ps

// Signs (func 0) or verifies (func 1) one word at a time using the configured p, q, seed h
// and private key x; the generator is rederived for every word and the public key for
// every verify word. Modular multiplies and divisions run on one shared unit at one bit
// per cycle. An exponentiation takes up to two multiplies per exponent bit; an inversion
// takes two divisions, a multiply, a subtraction and four moves per Euclid step. A new
// request is taken once the previous word's work is finished, while its result may
// still wait on rsp_stall.
module dsa_sign_and_verify #(
   parameter int MOD_BITS = dsa_pkg::DSA_MOD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dsa_pkg::dsa_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dsa_pkg::dsa_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [dsa_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [dsa_pkg::CSR_WIDTH-1:0]     csr_wdata
);
   import dsa_pkg::*;

   dsa_cmd_type    cmd;
   dsa_status_type status;

   dsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_data.func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dsa_datapath #(
      .MOD_BITS (MOD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/dsa_datapath.sv =====
// Datapath: config and work registers plus the iterative modular multiply / divide unit.
`timescale 1ns / 1ps

module dsa_datapath #(
   parameter int MOD_BITS = dsa_pkg::DSA_MOD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [dsa_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [dsa_pkg::CSR_WIDTH-1:0]     csr_wdata,
   input  dsa_pkg::dsa_req_type              req_data,
   input  dsa_pkg::dsa_cmd_type              cmd,
   output dsa_pkg::dsa_status_type           status,
   output dsa_pkg::dsa_rsp_type              rsp_data
);
   import dsa_pkg::*;

   localparam int W  = MOD_BITS;
   localparam int CW = $clog2(W);

   logic [CSR_WIDTH-1:0] p_cfg_ff, q_cfg_ff, h_cfg_ff, x_cfg_ff;
   logic [W-1:0] hs_ff, k_ff, r_ff, s_ff;
   logic [W-1:0] xr_ff, hr_ff, exp_ff, base_ff, acc_ff, g_ff, y_ff, w_ff;
   logic [W-1:0] u1_ff, u2_ff, t0_ff, t1_ff, t2_ff, t3_ff, r0_ff, r1_ff;
   logic [W-1:0] quo_ff, vr_ff, vs_ff;
   dsa_rsp_type  rsp_ff;

   logic [W-1:0] p_val, q_val, h_val, x_val;
   logic [W-1:0] opa, opb, opm;

   // iterative unit
   logic          busy_ff;
   logic [CW-1:0] cnt_ff;
   dsa_op_type    uop_ff;
   dsa_sel_type   udest_ff;
   logic [W-1:0]  ua_ff, ub_ff, um_ff, uacc_ff;

   logic [W-1:0] dbl, mul_next, rem_next, quo_next, imm, wr_val;
   logic [W:0]   div_t;
   logic [W:0]   div_diff;
   logic         div_ge, imm_op, done;
   dsa_sel_type  wr_dest;

   function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[W-1:0];
   endfunction

   assign p_val = W'(p_cfg_ff);
   assign q_val = W'(q_cfg_ff);
   assign h_val = W'(h_cfg_ff);
   assign x_val = W'(x_cfg_ff);

   function automatic logic [W-1:0] read_sel(input dsa_sel_type sel);
      logic [W-1:0] v;
      case (sel)
         SEL_ZERO: v = '0;
         SEL_ONE:  v = W'(1);
         SEL_P:    v = p_val;
         SEL_PM1:  v = p_val - W'(1);
         SEL_Q:    v = q_val;
         SEL_H:    v = h_val;
         SEL_X:    v = x_val;
         SEL_HS:   v = hs_ff;
         SEL_K:    v = k_ff;
         SEL_R:    v = r_ff;
         SEL_S:    v = s_ff;
         SEL_XR:   v = xr_ff;
         SEL_HR:   v = hr_ff;
         SEL_EXP:  v = exp_ff;
         SEL_BASE: v = base_ff;
         SEL_ACC:  v = acc_ff;
         SEL_G:    v = g_ff;
         SEL_Y:    v = y_ff;
         SEL_W:    v = w_ff;
         SEL_U1:   v = u1_ff;
         SEL_U2:   v = u2_ff;
         SEL_T0:   v = t0_ff;
         SEL_T1:   v = t1_ff;
         SEL_T2:   v = t2_ff;
         SEL_T3:   v = t3_ff;
         SEL_R0:   v = r0_ff;
         SEL_R1:   v = r1_ff;
         SEL_QUO:  v = quo_ff;
         SEL_VR:   v = vr_ff;
         SEL_VS:   v = vs_ff;
         default:  v = '0;
      endcase
      return v;
   endfunction

   assign opa = read_sel(cmd.src_a);
   assign opb = read_sel(cmd.src_b);
   assign opm = read_sel(cmd.src_m);

   // one multiply bit (MSB first: double, then add) and one restoring divide bit per cycle
   always_comb begin
      dbl      = add_mod(uacc_ff, uacc_ff, um_ff);
      mul_next = ub_ff[W-1] ? add_mod(dbl, ua_ff, um_ff) : dbl;
      div_t    = {uacc_ff, ub_ff[W-1]};
      div_ge   = (div_t >= {1'b0, ua_ff});
      div_diff = div_t - {1'b0, ua_ff};
      rem_next = div_ge ? div_diff[W-1:0] : div_t[W-1:0];
      quo_next = {ub_ff[W-2:0], div_ge};
   end

   always_comb begin
      imm_op = 1'b1;
      case (cmd.op)
         OP_MOV:  imm = opa;
         OP_SHR:  imm = opa >> 1;
         OP_ADDM: imm = add_mod(opa, opb, opm);
         OP_SUBM: imm = (opa - opb) + ((opa < opb) ? opm : '0);
         default: begin
            imm    = '0;
            imm_op = 1'b0;
         end
      endcase
   end

   assign done    = (cmd.go && !busy_ff && imm_op) || (busy_ff && cnt_ff == '0);
   assign wr_val  = busy_ff ? ((uop_ff == OP_DIV) ? rem_next : mul_next) : imm;
   assign wr_dest = busy_ff ? udest_ff : cmd.dest;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == '0) busy_ff <= 1'b0;
      end else if (cmd.go && !imm_op) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(W - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         uacc_ff <= (uop_ff == OP_DIV) ? rem_next : mul_next;
         ub_ff   <= (uop_ff == OP_DIV) ? quo_next : {ub_ff[W-2:0], 1'b0};
      end else if (cmd.go && !imm_op) begin
         uop_ff   <= cmd.op;
         udest_ff <= cmd.dest;
         um_ff    <= opm;
         uacc_ff  <= '0;
         if (cmd.op == OP_DIV) begin
            ub_ff <= opa;
            ua_ff <= opb;
         end else begin
            ua_ff <= opa;
            ub_ff <= opb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_cfg_ff <= RST_MODULUS_P;
         q_cfg_ff <= RST_ORDER_Q;
         h_cfg_ff <= RST_GENERATOR_SEED;
         x_cfg_ff <= RST_PRIVATE_KEY;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS_P:      p_cfg_ff <= csr_wdata;
            CSR_ORDER_Q:        q_cfg_ff <= csr_wdata;
            CSR_GENERATOR_SEED: h_cfg_ff <= csr_wdata;
            CSR_PRIVATE_KEY:    x_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         hs_ff <= W'(req_data.hash_value);
         k_ff  <= W'(req_data.nonce);
         r_ff  <= W'(req_data.sig_r);
         s_ff  <= W'(req_data.sig_s);
         vr_ff <= '0;
         vs_ff <= '0;
      end
      // quotient goes to QUO unless QUO is where the remainder lands
      if (done && busy_ff && uop_ff == OP_DIV && wr_dest != SEL_QUO) quo_ff <= quo_next;
      if (done) begin
         case (wr_dest)
            SEL_XR:   xr_ff   <= wr_val;
            SEL_HR:   hr_ff   <= wr_val;
            SEL_EXP:  exp_ff  <= wr_val;
            SEL_BASE: base_ff <= wr_val;
            SEL_ACC:  acc_ff  <= wr_val;
            SEL_G:    g_ff    <= wr_val;
            SEL_Y:    y_ff    <= wr_val;
            SEL_W:    w_ff    <= wr_val;
            SEL_U1:   u1_ff   <= wr_val;
            SEL_U2:   u2_ff   <= wr_val;
            SEL_T0:   t0_ff   <= wr_val;
            SEL_T1:   t1_ff   <= wr_val;
            SEL_T2:   t2_ff   <= wr_val;
            SEL_T3:   t3_ff   <= wr_val;
            SEL_R0:   r0_ff   <= wr_val;
            SEL_R1:   r1_ff   <= wr_val;
            SEL_QUO:  quo_ff  <= wr_val;
            SEL_VR:   vr_ff   <= wr_val;
            SEL_VS:   vs_ff   <= wr_val;
            default: ;
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_ff.out_r       <= 32'(vr_ff);
         rsp_ff.out_s       <= 32'(vs_ff);
         rsp_ff.verified    <= cmd.verified;
         rsp_ff.bad_operand <= cmd.bad_operand;
      end
   end

   assign rsp_data = rsp_ff;

   always_comb begin
      status.done         = done;
      status.p_lt2        = (p_val < W'(2));
      status.q_lt2        = (q_val < W'(2));
      status.pq_zero      = (p_val == '0) || (q_val == '0);
      status.exp_zero     = (exp_ff == '0);
      status.exp_lsb      = exp_ff[0];
      status.r1_zero      = (r1_ff == '0);
      status.r0_one       = (r0_ff == W'(1));
      status.sig_in_range = (r_ff != '0) && (r_ff < q_val) && (s_ff != '0) && (s_ff < q_val);
      status.v_eq_r       = (vr_ff == r_ff);
   end

endmodule

// ===== hw/rtl/dsa_ctrl.sv =====
// Controller: sequences the sign / verify steps, exponentiation and inversion routines.
`timescale 1ns / 1ps

module dsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  dsa_pkg::dsa_status_type status,
   output dsa_pkg::dsa_cmd_type    cmd
);
   import dsa_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE, ST_XRED, ST_HRED, ST_EXQ, ST_EXMV, ST_GSET, ST_GRET,
      ST_KBASE, ST_KEXP, ST_RRED, ST_KINV, ST_SGN, ST_SUM, ST_SVAL,
      ST_WINV, ST_WCHK, ST_YBASE, ST_YEXP, ST_YRET, ST_U1M, ST_RRD, ST_U2M,
      ST_P1B, ST_P1E, ST_P1R, ST_P2B, ST_P2E, ST_P2M, ST_VRED, ST_CMP, ST_DONE,
      ST_PW_CHK, ST_PW_ONE, ST_PW_TEST, ST_PW_MUL, ST_PW_SQR, ST_PW_SHR,
      ST_IV_R0, ST_IV_T0, ST_IV_T1, ST_IV_TEST, ST_IV_DIV, ST_IV_QRED,
      ST_IV_PROD, ST_IV_NT, ST_IV_M0, ST_IV_M1, ST_IV_M2, ST_IV_M3
   } state_type;

   state_type state_ff, ret_ff;
   logic      func_ff, ok_ff, bad_ff, rsp_valid_ff;
   logic      out_free;

   function automatic dsa_cmd_type issue(input dsa_op_type op, input dsa_sel_type a,
                                         input dsa_sel_type b, input dsa_sel_type m,
                                         input dsa_sel_type d);
      dsa_cmd_type c;
      c = '0;
      c.go    = 1'b1;
      c.op    = op;
      c.src_a = a;
      c.src_b = b;
      c.src_m = m;
      c.dest  = d;
      return c;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_XRED:  cmd = status.q_lt2 ? issue(OP_MOV, SEL_ZERO, SEL_ZERO, SEL_Q, SEL_XR)
                                      : issue(OP_DIV, SEL_X, SEL_Q, SEL_Q, SEL_XR);
         ST_HRED:  cmd = status.q_lt2 ? issue(OP_MOV, SEL_ZERO, SEL_ZERO, SEL_Q, SEL_HR)
                                      : issue(OP_DIV, SEL_HS, SEL_Q, SEL_Q, SEL_HR);
         ST_EXQ:   cmd = status.pq_zero ? issue(OP_MOV, SEL_ZERO, SEL_ZERO, SEL_Q, SEL_EXP)
                                        : issue(OP_DIV, SEL_PM1, SEL_Q, SEL_Q, SEL_T2);
         ST_EXMV:  cmd = issue(OP_MOV, SEL_QUO, SEL_ZERO, SEL_Q, SEL_EXP);
         ST_GSET:  cmd = issue(OP_MOV, SEL_H, SEL_ZERO, SEL_Q, SEL_BASE);
         ST_GRET:  cmd = issue(OP_MOV, SEL_ACC, SEL_ZERO, SEL_Q, SEL_G);
         ST_KBASE: cmd = issue(OP_MOV, SEL_G, SEL_ZERO, SEL_Q, SEL_BASE);
         ST_KEXP:  cmd = issue(OP_MOV, SEL_K, SEL_ZERO, SEL_Q, SEL_EXP);
         ST_RRED:  cmd = status.q_lt2 ? issue(OP_MOV, SEL_ZERO, SEL_ZERO, SEL_Q, SEL_VR)
                                      : issue(OP_DIV, SEL_ACC, SEL_Q, SEL_Q, SEL_VR);
         ST_KINV:  if (!status.q_lt2) cmd = issue(OP_DIV, SEL_K, SEL_Q, SEL_Q, SEL_R1);
         ST_SGN:   if (status.r0_one) cmd = issue(OP_MULM, SEL_XR, SEL_VR, SEL_Q, SEL_T2);
         ST_SUM:   cmd = issue(OP_ADDM, SEL_HR, SEL_T2, SEL_Q, SEL_T2);
         ST_SVAL:  cmd = issue(OP_MULM, SEL_T0, SEL_T2, SEL_Q, SEL_VS);
         ST_WINV:  if (!status.q_lt2) cmd = issue(OP_DIV, SEL_S, SEL_Q, SEL_Q, SEL_R1);
         ST_WCHK:  if (status.r0_one) cmd = issue(OP_MOV, SEL_T0, SEL_ZERO, SEL_Q, SEL_W);
         ST_YBASE: cmd = issue(OP_MOV, SEL_G, SEL_ZERO, SEL_Q, SEL_BASE);
         ST_YEXP:  cmd = issue(OP_MOV, SEL_XR, SEL_ZERO, SEL_Q, SEL_EXP);
         ST_YRET:  cmd = issue(OP_MOV, SEL_ACC, SEL_ZERO, SEL_Q, SEL_Y);
         ST_U1M:   cmd = issue(OP_MULM, SEL_HR, SEL_W, SEL_Q, SEL_U1);
         ST_RRD:   cmd = issue(OP_DIV, SEL_R, SEL_Q, SEL_Q, SEL_T2);
         ST_U2M:   cmd = issue(OP_MULM, SEL_T2, SEL_W, SEL_Q, SEL_U2);
         ST_P1B:   cmd = issue(OP_MOV, SEL_G, SEL_ZERO, SEL_Q, SEL_BASE);
         ST_P1E:   cmd = issue(OP_MOV, SEL_U1, SEL_ZERO, SEL_Q, SEL_EXP);
         ST_P1R:   cmd = issue(OP_MOV, SEL_ACC, SEL_ZERO, SEL_Q, SEL_T3);
         ST_P2B:   cmd = issue(OP_MOV, SEL_Y, SEL_ZERO, SEL_Q, SEL_BASE);
         ST_P2E:   cmd = issue(OP_MOV, SEL_U2, SEL_ZERO, SEL_Q, SEL_EXP);
         ST_P2M:   cmd = status.p_lt2 ? issue(OP_MOV, SEL_ZERO, SEL_ZERO, SEL_P, SEL_T2)
                                      : issue(OP_MULM, SEL_T3, SEL_ACC, SEL_P, SEL_T2);
         ST_VRED:  cmd = status.q_lt2 ? issue(OP_MOV, SEL_ZERO, SEL_ZERO, SEL_Q, SEL_VR)
                                      : issue(OP_DIV, SEL_T2, SEL_Q, SEL_Q, SEL_VR);
         ST_PW_CHK: cmd = status.p_lt2 ? issue(OP_MOV, SEL_ZERO, SEL_ZERO, SEL_P, SEL_ACC)
                                       : issue(OP_DIV, SEL_BASE, SEL_P, SEL_P, SEL_BASE);
         ST_PW_ONE: cmd = issue(OP_MOV, SEL_ONE, SEL_ZERO, SEL_P, SEL_ACC);
         ST_PW_MUL: cmd = issue(OP_MULM, SEL_ACC, SEL_BASE, SEL_P, SEL_ACC);
         ST_PW_SQR: cmd = issue(OP_MULM, SEL_BASE, SEL_BASE, SEL_P, SEL_BASE);
         ST_PW_SHR: cmd = issue(OP_SHR, SEL_EXP, SEL_ZERO, SEL_P, SEL_EXP);
         ST_IV_R0:  cmd = issue(OP_MOV, SEL_Q, SEL_ZERO, SEL_Q, SEL_R0);
         ST_IV_T0:  cmd = issue(OP_MOV, SEL_ZERO, SEL_ZERO, SEL_Q, SEL_T0);
         ST_IV_T1:  cmd = issue(OP_MOV, SEL_ONE, SEL_ZERO, SEL_Q, SEL_T1);
         ST_IV_DIV: cmd = issue(OP_DIV, SEL_R0, SEL_R1, SEL_Q, SEL_T2);
         ST_IV_QRED: cmd = issue(OP_DIV, SEL_QUO, SEL_Q, SEL_Q, SEL_QUO);
         ST_IV_PROD: cmd = issue(OP_MULM, SEL_QUO, SEL_T1, SEL_Q, SEL_T3);
         ST_IV_NT:  cmd = issue(OP_SUBM, SEL_T0, SEL_T3, SEL_Q, SEL_T3);
         ST_IV_M0:  cmd = issue(OP_MOV, SEL_R1, SEL_ZERO, SEL_Q, SEL_R0);
         ST_IV_M1:  cmd = issue(OP_MOV, SEL_T2, SEL_ZERO, SEL_Q, SEL_R1);
         ST_IV_M2:  cmd = issue(OP_MOV, SEL_T1, SEL_ZERO, SEL_Q, SEL_T0);
         ST_IV_M3:  cmd = issue(OP_MOV, SEL_T3, SEL_ZERO, SEL_Q, SEL_T1);
         default:   cmd = '0;
      endcase
      cmd.latch_item  = (state_ff == ST_IDLE) && req_valid;
      cmd.load_rsp    = (state_ff == ST_DONE) && out_free;
      cmd.verified    = ok_ff;
      cmd.bad_operand = bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         func_ff      <= FUNC_SIGN;
         ok_ff        <= 1'b0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               func_ff  <= req_func;
               ok_ff    <= 1'b0;
               bad_ff   <= 1'b0;
               state_ff <= ST_XRED;
            end
            ST_XRED: if (status.done) state_ff <= ST_HRED;
            ST_HRED: if (status.done) state_ff <= ST_EXQ;
            ST_EXQ:  if (status.done) state_ff <= status.pq_zero ? ST_GSET : ST_EXMV;
            ST_EXMV: if (status.done) state_ff <= ST_GSET;
            ST_GSET: if (status.done) begin
               ret_ff   <= ST_GRET;
               state_ff <= ST_PW_CHK;
            end
            ST_GRET: if (status.done)
               state_ff <= (func_ff == FUNC_VERIFY) ? ST_WINV : ST_KBASE;
            // sign
            ST_KBASE: if (status.done) state_ff <= ST_KEXP;
            ST_KEXP: if (status.done) begin
               ret_ff   <= ST_RRED;
               state_ff <= ST_PW_CHK;
            end
            ST_RRED: if (status.done) state_ff <= ST_KINV;
            ST_KINV: if (status.q_lt2) begin
               bad_ff   <= 1'b1;
               state_ff <= ST_DONE;
            end else if (status.done) begin
               ret_ff   <= ST_SGN;
               state_ff <= ST_IV_R0;
            end
            ST_SGN: if (!status.r0_one) begin
               bad_ff   <= 1'b1;
               state_ff <= ST_DONE;
            end else if (status.done) state_ff <= ST_SUM;
            ST_SUM:  if (status.done) state_ff <= ST_SVAL;
            ST_SVAL: if (status.done) state_ff <= ST_DONE;
            // verify
            ST_WINV: if (status.q_lt2) begin
               bad_ff   <= 1'b1;
               state_ff <= ST_DONE;
            end else if (status.done) begin
               ret_ff   <= ST_WCHK;
               state_ff <= ST_IV_R0;
            end
            ST_WCHK: if (!status.r0_one) begin
               bad_ff   <= 1'b1;
               state_ff <= ST_DONE;
            end else if (status.done) state_ff <= ST_YBASE;
            ST_YBASE: if (status.done) state_ff <= ST_YEXP;
            ST_YEXP: if (status.done) begin
               ret_ff   <= ST_YRET;
               state_ff <= ST_PW_CHK;
            end
            ST_YRET: if (status.done) state_ff <= ST_U1M;
            ST_U1M:  if (status.done) state_ff <= ST_RRD;
            ST_RRD:  if (status.done) state_ff <= ST_U2M;
            ST_U2M:  if (status.done) state_ff <= ST_P1B;
            ST_P1B:  if (status.done) state_ff <= ST_P1E;
            ST_P1E: if (status.done) begin
               ret_ff   <= ST_P1R;
               state_ff <= ST_PW_CHK;
            end
            ST_P1R:  if (status.done) state_ff <= ST_P2B;
            ST_P2B:  if (status.done) state_ff <= ST_P2E;
            ST_P2E: if (status.done) begin
               ret_ff   <= ST_P2M;
               state_ff <= ST_PW_CHK;
            end
            ST_P2M:  if (status.done) state_ff <= ST_VRED;
            ST_VRED: if (status.done) state_ff <= ST_CMP;
            ST_CMP: begin
               ok_ff    <= status.sig_in_range && status.v_eq_r;
               state_ff <= ST_DONE;
            end
            ST_DONE: if (out_free) begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            // ACC = BASE ^ EXP mod p, right-to-left square and multiply
            ST_PW_CHK: if (status.done) state_ff <= status.p_lt2 ? ret_ff : ST_PW_ONE;
            ST_PW_ONE: if (status.done) state_ff <= ST_PW_TEST;
            ST_PW_TEST: begin
               if (status.exp_zero)     state_ff <= ret_ff;
               else if (status.exp_lsb) state_ff <= ST_PW_MUL;
               else                     state_ff <= ST_PW_SQR;
            end
            ST_PW_MUL: if (status.done) state_ff <= ST_PW_SQR;
            ST_PW_SQR: if (status.done) state_ff <= ST_PW_SHR;
            ST_PW_SHR: if (status.done) state_ff <= ST_PW_TEST;
            // extended Euclid mod q on R1; inverse ends in T0 when R0 is one
            ST_IV_R0:   if (status.done) state_ff <= ST_IV_T0;
            ST_IV_T0:   if (status.done) state_ff <= ST_IV_T1;
            ST_IV_T1:   if (status.done) state_ff <= ST_IV_TEST;
            ST_IV_TEST: state_ff <= status.r1_zero ? ret_ff : ST_IV_DIV;
            ST_IV_DIV:  if (status.done) state_ff <= ST_IV_QRED;
            ST_IV_QRED: if (status.done) state_ff <= ST_IV_PROD;
            ST_IV_PROD: if (status.done) state_ff <= ST_IV_NT;
            ST_IV_NT:   if (status.done) state_ff <= ST_IV_M0;
            ST_IV_M0:   if (status.done) state_ff <= ST_IV_M1;
            ST_IV_M1:   if (status.done) state_ff <= ST_IV_M2;
            ST_IV_M2:   if (status.done) state_ff <= ST_IV_M3;
            ST_IV_M3:   if (status.done) state_ff <= ST_IV_TEST;
            default:    state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== verif/tb_dsa_sign_and_verify.sv =====
// Self-checking testbench for the DSA sign and verify block.
`timescale 1ns / 1ps

module tb_dsa_sign_and_verify;
   import dsa_pkg::*;

   localparam int STALL_LIMIT = 300000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   dsa_req_type             req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   dsa_rsp_type             rsp_data;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_WIDTH-1:0]    csr_wdata;

   dsa_sign_and_verify uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // mirror of the key registers
   logic [31:0] cur_p, cur_q, cur_h, cur_x;

   dsa_rsp_type pending_words[$];
   logic        failed;
   logic        quiet;
   int          idle_cycles;
   int          stall_burst;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // modular helpers, every product taken at 64 bits
   function automatic logic [63:0] mulm(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      if (m < 2) return 0;
      return ((a % m) * (b % m)) % m;
   endfunction

   function automatic logic [63:0] powm(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      if (m < 2) return 0;
      acc = 1;
      b = b % m;
      while (e != 0) begin
         if (e[0]) acc = mulm(acc, b, m);
         b = mulm(b, b, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic logic invm(logic [63:0] a, logic [63:0] m, output logic [63:0] res);
      logic [63:0] r0, r1, t0, t1, quo, nr, nt;
      res = 0;
      if (m < 2) return 1'b0;
      r0 = m;
      r1 = a % m;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
         quo = r0 / r1;
         nr  = r0 - quo * r1;
         nt  = (t0 + (m - mulm(quo, t1, m)) % m) % m;
         r0 = r1; r1 = nr;
         t0 = t1; t1 = nt;
      end
      if (r0 != 1) return 1'b0;
      res = t0;
      return 1'b1;
   endfunction

   function automatic dsa_rsp_type dsa_expected(dsa_req_type rq);
      dsa_rsp_type rs;
      logic [63:0] p, q, x, hs, ex, g, k, kinv, w, y, u1, u2, v, r, s, t;
      p  = cur_p;
      q  = cur_q;
      x  = (q < 2) ? 0 : cur_x % q;
      hs = (q < 2) ? 0 : rq.hash_value % q;
      ex = (q == 0 || p == 0) ? 0 : (p - 1) / q;
      g  = powm(cur_h, ex, p);
      rs = '0;
      if (rq.func == FUNC_SIGN) begin
         k = rq.nonce;
         t = (q < 2) ? 0 : powm(g, k, p) % q;
         rs.out_r = t[31:0];
         if (invm(k, q, kinv)) begin
            t = mulm(kinv, (hs + mulm(x, rs.out_r, q)) % q, q);
            rs.out_s = t[31:0];
         end else begin
            rs.bad_operand = 1'b1;
         end
      end else begin
         r = rq.sig_r;
         s = rq.sig_s;
         if (invm(s, q, w)) begin
            y  = powm(g, x, p);
            u1 = mulm(hs, w, q);
            u2 = mulm(r, w, q);
            v  = mulm(powm(g, u1, p), powm(y, u2, p), p);
            v  = (q < 2) ? 0 : v % q;
            rs.out_r = v[31:0];
            rs.verified = (r != 0 && r < q && s != 0 && s < q && v == r);
         end else begin
            rs.bad_operand = 1'b1;
         end
      end
      return rs;
   endfunction

   // result side: random stall bursts
   always @(negedge clock) begin
      if (stall_burst > 0) begin
         stall_burst <= stall_burst - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         stall_burst <= $urandom_range(1, 9);
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      dsa_rsp_type exp_word;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               $error("result word with nothing expected");
               failed = 1'b1;
            end else begin
               exp_word = pending_words.pop_front();
               if (rsp_data.out_r !== exp_word.out_r) begin
                  $error("out_r expected %0h got %0h", exp_word.out_r, rsp_data.out_r);
                  failed = 1'b1;
               end
               if (rsp_data.out_s !== exp_word.out_s) begin
                  $error("out_s expected %0h got %0h", exp_word.out_s, rsp_data.out_s);
                  failed = 1'b1;
               end
               if (rsp_data.verified !== exp_word.verified) begin
                  $error("verified expected %0b got %0b", exp_word.verified,
                         rsp_data.verified);
                  failed = 1'b1;
               end
               if (rsp_data.bad_operand !== exp_word.bad_operand) begin
                  $error("bad_operand expected %0b got %0b", exp_word.bad_operand,
                         rsp_data.bad_operand);
                  failed = 1'b1;
               end
            end
         end
         if (idle_cycles > STALL_LIMIT) begin
            $display("dsa_sign_and_verify verification failed");
            $finish;
         end
      end
   end

   task automatic send_word(input dsa_req_type rq);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 9);
         repeat (gap) @(negedge clock);
      end
      req_data  <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_words.push_back(dsa_expected(rq));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic write_keys(input logic [31:0] p, q, h, x);
      wait (pending_words.size() == 0);
      repeat (4) @(negedge clock);
      csr_we <= 1'b1; csr_index <= CSR_MODULUS_P;      csr_wdata <= p;
      @(negedge clock);
      csr_index <= CSR_ORDER_Q;        csr_wdata <= q;
      @(negedge clock);
      csr_index <= CSR_GENERATOR_SEED; csr_wdata <= h;
      @(negedge clock);
      csr_index <= CSR_PRIVATE_KEY;    csr_wdata <= x;
      @(negedge clock);
      csr_we <= 1'b0;
      cur_p = p; cur_q = q; cur_h = h; cur_x = x;
   endtask

   function automatic dsa_req_type make_word(logic f, logic [31:0] hv, k, r, s);
      dsa_req_type rq;
      rq.func = f; rq.hash_value = hv; rq.nonce = k; rq.sig_r = r; rq.sig_s = s;
      return rq;
   endfunction

   // sign the given hash, then verify the produced signature (tampered when tamper is set)
   task automatic sign_then_check(input logic [31:0] hv, k, input logic tamper);
      dsa_rsp_type sig;
      logic [31:0] r, s;
      sig = dsa_expected(make_word(FUNC_SIGN, hv, k, $urandom, $urandom));
      send_word(make_word(FUNC_SIGN, hv, k, $urandom, $urandom));
      r = sig.out_r;
      s = sig.out_s;
      if (tamper) begin
         if ($urandom_range(0, 1)) r = r ^ (32'd1 << $urandom_range(0, 31));
         else hv = hv + 1;
      end
      send_word(make_word(FUNC_VERIFY, hv, $urandom, r, s));
   endtask

   task automatic test_reset_keys;
      cur_p = RST_MODULUS_P; cur_q = RST_ORDER_Q;
      cur_h = RST_GENERATOR_SEED; cur_x = RST_PRIVATE_KEY;
      send_word(make_word(FUNC_SIGN, 32'd0, 32'd0, 32'd0, 32'd0));
      send_word(make_word(FUNC_SIGN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1));
      send_word(make_word(FUNC_SIGN, 32'd5, 32'd11, 32'd0, 32'd0));
      send_word(make_word(FUNC_VERIFY, 32'd5, 32'd0, 32'd0, 32'd0));
      send_word(make_word(FUNC_VERIFY, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_word(make_word(FUNC_VERIFY, 32'd3, 32'd0, 32'd14, 32'd3));
      sign_then_check(32'd7, 32'd4, 1'b0);
   endtask

   task automatic test_tiny_modulus;
      write_keys(32'd0, 32'd11, 32'd2, 32'd3);
      send_word(make_word(FUNC_SIGN, 32'd9, 32'd3, 32'd0, 32'd0));
      send_word(make_word(FUNC_VERIFY, 32'd9, 32'd0, 32'd1, 32'd2));
      write_keys(32'd1, 32'd11, 32'd2, 32'd3);
      send_word(make_word(FUNC_SIGN, 32'd9, 32'd3, 32'd0, 32'd0));
   endtask

   task automatic test_tiny_order;
      write_keys(32'd23, 32'd0, 32'd5, 32'd3);
      send_word(make_word(FUNC_SIGN, 32'd9, 32'd3, 32'd0, 32'd0));
      send_word(make_word(FUNC_VERIFY, 32'd9, 32'd0, 32'd1, 32'd1));
      write_keys(32'd23, 32'd1, 32'd5, 32'd3);
      send_word(make_word(FUNC_SIGN, 32'd9, 32'd3, 32'd0, 32'd0));
      send_word(make_word(FUNC_VERIFY, 32'd9, 32'd0, 32'd1, 32'd1));
   endtask

   task automatic test_extreme_keys;
      write_keys('1, '1, '1, '1);
      send_word(make_word(FUNC_SIGN, '1, 32'h1234_5677, 32'd0, 32'd0));
      send_word(make_word(FUNC_VERIFY, '1, 32'd0, '1, 32'h0000_0007));
      write_keys(32'd4294967291, 32'd22605091, 32'd3, 32'd22605090);
      sign_then_check(32'hDEAD_BEEF, 32'hFFFF_FFFE, 1'b0);
   endtask

   task automatic test_random_traffic(input int pairs);
      logic [31:0] p_set[4] = '{32'd23, 32'd607, 32'd2147483647, 32'd4294967291};
      logic [31:0] q_set[4] = '{32'd11, 32'd101, 32'd331, 32'd22605091};
      int sel;
      for (int i = 0; i < pairs; i++) begin
         if (i % 8 == 0) begin
            sel = $urandom_range(0, 3);
            write_keys(p_set[sel], q_set[sel], $urandom_range(2, 32'hFFFF_FFFF),
                       (i % 16 == 0) ? $urandom : $urandom_range(1, q_set[sel] - 1));
         end
         if (i >= pairs - 6) quiet = 1'b1;
         if ($urandom_range(0, 4) == 0)
            send_word(make_word(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                                $urandom));
         else
            sign_then_check($urandom, $urandom, $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      failed      = 1'b0;
      quiet       = 1'b0;
      idle_cycles = 0;
      stall_burst = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_MODULUS_P;
      csr_wdata   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_keys;
      test_tiny_modulus;
      test_tiny_order;
      test_extreme_keys;
      test_random_traffic(48);

      wait (pending_words.size() == 0);
      repeat (50) @(posedge clock);
      if (!failed)
         $display("dsa_sign_and_verify verification clean");
      else
         $display("dsa_sign_and_verify verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dsa_pkg.sv
hw/rtl/dsa_datapath.sv
hw/rtl/dsa_ctrl.sv
hw/rtl/dsa_sign_and_verify.sv
verif/tb_dsa_sign_and_verify.sv
